// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by cpvg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define CPVG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define CPVG_ASSERT_IMP(label, ante, cons, msg) \
	`CPVG_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/cpvg_pkg.sv =====
package cpvg_pkg;

	localparam int VERTEX_COUNT = 36;
	localparam int ANGLE_STEPS = 36;

	// Root extraction: two result bits per pipeline stage over a 36-bit radicand.
	localparam int SQRT_STEPS = 18;
	localparam int SQRT_STEPS_PER_STAGE = 2;
	localparam int SQRT_STAGES = SQRT_STEPS / SQRT_STEPS_PER_STAGE;

	localparam logic [5:0] LAST_NUMBER = 6'(VERTEX_COUNT - 1);
	localparam logic [5:0] LAST_ANGLE = 6'(ANGLE_STEPS - 1);
	localparam logic [5:0] QUARTER = 6'(ANGLE_STEPS / 4);
	localparam logic [5:0] HALF = 6'(ANGLE_STEPS / 2);
	localparam logic [5:0] THREE_QUARTERS = 6'(3 * ANGLE_STEPS / 4);
	localparam logic [5:0] FULL_TURN = 6'(ANGLE_STEPS);

	typedef struct packed {
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic signed [15:0] rim_x;
		logic signed [15:0] rim_y;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic [5:0]         vertex_number;
		logic               last_vertex;
	} out_item_t;

	// Squared distance with the centre carried alongside.
	typedef struct packed {
		logic [32:0]        sum;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
	} sq_item_t;

	// Working state of the digit-by-digit square root.
	typedef struct packed {
		logic [35:0]        n;
		logic [17:0]        root;
		logic [20:0]        rem;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
	} sqst_t;

	// cos of 0, 10, ... 90 degrees in Q1.15.
	function automatic logic [15:0] quarter_cos(input logic [3:0] i);
		logic [15:0] v;
		case (i)
			4'd0: v = 16'd32767;
			4'd1: v = 16'd32270;
			4'd2: v = 16'd30793;
			4'd3: v = 16'd28378;
			4'd4: v = 16'd25102;
			4'd5: v = 16'd21063;
			4'd6: v = 16'd16384;
			4'd7: v = 16'd11207;
			4'd8: v = 16'd5690;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// Cosine of angle step a (0 to 35) folded onto the first quadrant.
	function automatic logic signed [15:0] trig_q15(input logic [5:0] a);
		logic [5:0] d;
		logic neg;
		logic signed [15:0] m;
		if (a < QUARTER) begin
			d = a;
			neg = 1'b0;
		end else if (a < HALF) begin
			d = HALF - a;
			neg = 1'b1;
		end else if (a < THREE_QUARTERS) begin
			d = a - HALF;
			neg = 1'b1;
		end else begin
			d = FULL_TURN - a;
			neg = 1'b0;
		end
		m = signed'(quarter_cos(d[3:0]));
		return neg ? -m : m;
	endfunction

	// One restoring square-root step: brings down two radicand bits.
	function automatic sqst_t sqrt_step(input sqst_t s);
		sqst_t o;
		logic [20:0] rem2;
		logic [20:0] t;
		o = s;
		rem2 = {s.rem[18:0], s.n[35:34]};
		t = {1'b0, s.root, 2'b01};
		o.n = {s.n[33:0], 2'b00};
		if (rem2 >= t) begin
			o.rem = rem2 - t;
			o.root = {s.root[16:0], 1'b1};
		end else begin
			o.rem = rem2;
			o.root = {s.root[16:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// ===== rtl/core/cpvg_square.sv =====
module cpvg_square import cpvg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output sq_item_t  out_item
);

	logic               valid_s1, valid_s2, valid_s3;
	logic               adv1, adv2, adv3;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [15:0] cx_s1, cy_s1, cx_s2, cy_s2;
	logic [31:0]        sqx_s2, sqy_s2;
	sq_item_t           res_s3;
	logic signed [33:0] sqx_w, sqy_w;

	assign adv3 = !valid_s3 || out_ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign in_ready = adv1;

	assign sqx_w = dx_s1 * dx_s1;
	assign sqy_w = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			dx_s1 <= 17'(in_item.center_x) - 17'(in_item.rim_x);
			dy_s1 <= 17'(in_item.center_y) - 17'(in_item.rim_y);
			cx_s1 <= in_item.center_x;
			cy_s1 <= in_item.center_y;
		end
		if (adv2) begin
			// Each square is below 2^32, so the low word is exact.
			sqx_s2 <= sqx_w[31:0];
			sqy_s2 <= sqy_w[31:0];
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
		end
		if (adv3) begin
			res_s3.sum <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			res_s3.cx <= cx_s2;
			res_s3.cy <= cy_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_item = res_s3;

endmodule

// ===== rtl/core/cpvg_sqrt.sv =====
module cpvg_sqrt import cpvg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sq_item_t in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output sqst_t    out_item
);

	sqst_t                  stage_s [SQRT_STAGES];
	logic [SQRT_STAGES-1:0] valid_s;
	logic [SQRT_STAGES:0]   adv;
	sqst_t                  init_w;

	always_comb begin
		init_w.n = {3'b000, in_item.sum};
		init_w.root = '0;
		init_w.rem = '0;
		init_w.cx = in_item.cx;
		init_w.cy = in_item.cy;
	end

	assign adv[SQRT_STAGES] = out_ready;

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
		sqst_t src_w, nxt_w;
		logic  vin_w;

		if (i == 0) begin : g_first
			assign src_w = init_w;
			assign vin_w = in_valid;
		end else begin : g_rest
			assign src_w = stage_s[i-1];
			assign vin_w = valid_s[i-1];
		end

		always_comb begin
			nxt_w = src_w;
			for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
				nxt_w = sqrt_step(nxt_w);
			end
		end

		assign adv[i] = !valid_s[i] || adv[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (adv[i]) begin
				valid_s[i] <= vin_w;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[i]) stage_s[i] <= nxt_w;
		end
	end

	assign in_ready = adv[0];
	assign out_valid = valid_s[SQRT_STAGES-1];
	assign out_item = stage_s[SQRT_STAGES-1];

endmodule

// ===== rtl/core/cpvg_sweep.sv =====
module cpvg_sweep import cpvg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sqst_t     in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic               busy_q;
	logic [5:0]         k_q, ang_q;
	logic [16:0]        r_q;
	logic signed [15:0] cx_q, cy_q;
	logic               emit, at_last;
	logic [5:0]         sin_ang;
	logic signed [15:0] cos_w, sin_w;
	logic signed [33:0] px_w, py_w;

	logic               valid_s1, valid_s2, valid_s3;
	logic               adv1, adv2, adv3;
	logic signed [33:0] px_s1, py_s1;
	logic signed [15:0] cx_s1, cy_s1, cx_s2, cy_s2;
	logic [5:0]         num_s1, num_s2;
	logic               last_s1, last_s2;
	logic signed [18:0] qx_s2, qy_s2;
	out_item_t          res_s3;

	// Round to nearest with halves away from zero, as one add and a shift.
	function automatic logic signed [18:0] round_q15(input logic signed [33:0] p);
		logic signed [33:0] b;
		b = p + (p[33] ? 34'sd16383 : 34'sd16384);
		return b[33:15];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] o;
		if (v > 20'sd32767) begin
			o = 16'sh7FFF;
		end else if (v < -20'sd32768) begin
			o = 16'sh8000;
		end else begin
			o = v[15:0];
		end
		return o;
	endfunction

	assign adv3 = !valid_s3 || out_ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign at_last = (k_q == LAST_NUMBER);
	assign emit = busy_q && adv1;
	// The next circle loads in the cycle that the last vertex leaves.
	assign in_ready = !busy_q || (emit && at_last);

	assign sin_ang = (ang_q >= QUARTER) ? ang_q - QUARTER : ang_q + THREE_QUARTERS;
	assign cos_w = trig_q15(ang_q);
	assign sin_w = trig_q15(sin_ang);
	assign px_w = $signed({1'b0, r_q}) * cos_w;
	assign py_w = $signed({1'b0, r_q}) * sin_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
			ang_q <= '0;
		end else begin
			if (emit) begin
				if (at_last) busy_q <= 1'b0;
				k_q <= k_q + 6'd1;
				ang_q <= (ang_q == LAST_ANGLE) ? 6'd0 : ang_q + 6'd1;
			end
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				k_q <= '0;
				ang_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			// Round the root up when the remainder exceeds the root.
			r_q <= in_item.root[16:0] + 17'(in_item.rem > 21'(in_item.root));
			cx_q <= in_item.cx;
			cy_q <= in_item.cy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= emit;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			px_s1 <= px_w;
			py_s1 <= py_w;
			cx_s1 <= cx_q;
			cy_s1 <= cy_q;
			num_s1 <= k_q;
			last_s1 <= at_last;
		end
		if (adv2) begin
			qx_s2 <= round_q15(px_s1);
			qy_s2 <= round_q15(py_s1);
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			num_s2 <= num_s1;
			last_s2 <= last_s1;
		end
		if (adv3) begin
			res_s3.vertex_x <= sat16(20'(cx_s2) + 20'(qx_s2));
			res_s3.vertex_y <= sat16(20'(cy_s2) + 20'(qy_s2));
			res_s3.vertex_number <= num_s2;
			res_s3.last_vertex <= last_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_item = res_s3;

endmodule

// ===== rtl/core/circle_polygon_vertex_generator.sv =====
// Channel | Direction | Handshake          | Payload
// circle  | in        | in_valid/in_ready   | in_item (centre and rim point)
// vertex  | out       | out_valid/out_ready | out_item (one polygon vertex)
//
// A circle yields 36 vertices, one per cycle while the output is taken; the vertex
// sweep takes the next circle only as the last vertex of the current one leaves.
// On its way to the first vertex a circle passes the squared-distance pipeline,
// the root pipeline, the sweep's load register and the vertex pipeline, in that order.
// Reset clears only the valid bits and the sweep state.
// A stall holds every stage; up to twelve circles queue ahead of the sweep.
module circle_polygon_vertex_generator import cpvg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic     sq_valid, sq_ready;
	sq_item_t sq_item;
	logic     rt_valid, rt_ready;
	sqst_t    rt_item;

	cpvg_square u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_item  (sq_item)
	);

	cpvg_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.in_item   (sq_item),
		.out_valid (rt_valid),
		.out_ready (rt_ready),
		.out_item  (rt_item)
	);

	cpvg_sweep u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.in_ready  (rt_ready),
		.in_item   (rt_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/core/cpvg_checker.sv =====
`include "assert_macros.svh"

module cpvg_checker import cpvg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	logic [5:0] exp_q;
	logic [5:0] pending_q;
	logic       in_acc, out_acc, done, stalled, is_last;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign done = out_acc && out_item.last_vertex;
	assign stalled = out_valid && !out_ready;
	assign is_last = (out_item.vertex_number == LAST_NUMBER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			pending_q <= '0;
		end else begin
			if (out_acc) exp_q <= out_item.last_vertex ? 6'd0 : exp_q + 6'd1;
			pending_q <= pending_q + 6'(in_acc) - 6'(done);
		end
	end

	`CPVG_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_item), "vertex changed while stalled")
	`CPVG_ASSERT_IMP(a_vertex_order, out_valid, out_item.vertex_number == exp_q, "vertex out of sequence")
	`CPVG_ASSERT_IMP(a_last_mark, out_valid, out_item.last_vertex == is_last, "last mark on wrong vertex")
	`CPVG_ASSERT_IMP(a_no_orphan, out_valid, pending_q != 6'd0, "vertex with no circle outstanding")

endmodule

bind circle_polygon_vertex_generator cpvg_checker u_checker (.*);
